@@ sv/abst_pkg.sv @@
package abst_pkg;

    localparam int VALUE_W  = 32;
    localparam int CODE_W   = 2;

    typedef enum logic [CODE_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DUMP   = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        ORD_PRE  = 2'd0,
        ORD_IN   = 2'd1,
        ORD_POST = 2'd2
    } order_t;

    typedef enum logic [CODE_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_DMP_RD,
        S_DMP_EV,
        S_DMP_FLUSH,
        S_RESP
    } state_t;

    // how the walk arrived at the current slot
    typedef enum logic [1:0] {
        PH_DOWN,
        PH_LEFT,
        PH_RIGHT
    } phase_t;

    typedef struct packed {
        logic                load;
        logic [VALUE_W-1:0]  node_value;
        status_t             status;
        logic                last;
    } res_t;

endpackage

@@ sv/array_binary_search_tree_unit.sv @@
// channel  | dir | tdata                                  | tuser      | tlast
// s_axis   | in  | action[1:0] order[3:2] value[35:4]     | -          | -
// m_axis   | out | node_value[31:0]                       | status[1:0]| last
//
// the tree lives in one ram with separate read and write ports and a registered
// read, so every node step issues a read, then evaluates
// reset starts a clearing pass during which no request is taken
// one output register; m_axis stall holds the walk only when a second value is due
module array_binary_search_tree_unit #(
    parameter int LEVELS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[1:0], order[3:2], value[35:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // node_value[31:0]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    output logic        m_axis_tlast
);

    import abst_pkg::*;

    localparam int NODES = (1 << LEVELS) - 1;

    res_t                res;
    logic                out_free;
    logic                mem_we;
    logic [LEVELS-1:0]   mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [LEVELS-1:0]   mem_raddr;
    logic [VALUE_W-1:0]  mem_rdata;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    status_t             out_status_reg;
    logic                out_last_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    abst_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tdata[1:0]),
        .in_order  (s_axis_tdata[3:2]),
        .in_value  (s_axis_tdata[35:4]),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    abst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_value_reg  <= res.node_value;
            out_status_reg <= res.status;
            out_last_reg   <= res.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ sv/abst_ram.sv @@
module abst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 63
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/abst_ctrl.sv @@
module abst_ctrl #(
    parameter int LEVELS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [abst_pkg::CODE_W-1:0]   in_action,
    input  logic [abst_pkg::CODE_W-1:0]   in_order,
    input  logic [abst_pkg::VALUE_W-1:0]  in_value,
    input  logic                          out_free,
    output abst_pkg::res_t                res,
    output logic                          mem_we,
    output logic [LEVELS-1:0]             mem_waddr,
    output logic [abst_pkg::VALUE_W-1:0]  mem_wdata,
    output logic                          mem_re,
    output logic [LEVELS-1:0]             mem_raddr,
    input  logic [abst_pkg::VALUE_W-1:0]  mem_rdata
);

    import abst_pkg::*;

    localparam int                NODES     = (1 << LEVELS) - 1;
    localparam logic [LEVELS-1:0] LAST_ADDR = LEVELS'(NODES - 1);
    localparam logic [LEVELS:0]   ROOT      = (LEVELS+1)'(1);

    state_t               state_reg, state_next;
    logic [LEVELS:0]      slot_reg, slot_next;
    phase_t               phase_reg, phase_next;
    logic [CODE_W-1:0]    order_reg, order_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [LEVELS-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                 clr_resp_reg, clr_resp_next;
    status_t              resp_status_reg, resp_status_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [VALUE_W-1:0]   pend_value_reg, pend_value_next;

    logic                 node_empty;
    logic                 up_done;
    logic [LEVELS:0]      up_slot;
    phase_t               up_phase;
    logic [LEVELS:0]      left_slot;
    logic [LEVELS:0]      right_slot;
    logic [LEVELS:0]      slot_m1;
    logic                 dmp_emit;
    logic                 dmp_done;
    logic [LEVELS:0]      dmp_slot;
    phase_t               dmp_phase;
    logic                 stall;
    logic                 go_left;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_resp_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_resp_reg   <= clr_resp_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        phase_reg       <= phase_next;
        order_reg       <= order_next;
        value_reg       <= value_next;
        resp_status_reg <= resp_status_next;
        pend_value_reg  <= pend_value_next;
    end

    assign node_empty = slot_reg[LEVELS] || (mem_rdata == '0);
    assign up_done    = (slot_reg == ROOT);
    assign up_slot    = slot_reg >> 1;
    assign up_phase   = slot_reg[0] ? PH_RIGHT : PH_LEFT;
    assign left_slot  = {slot_reg[LEVELS-1:0], 1'b0};
    assign right_slot = {slot_reg[LEVELS-1:0], 1'b1};
    assign slot_m1    = slot_reg - ROOT;
    assign go_left    = $signed(value_reg) <= $signed(mem_rdata);

    // one step of the stackless walk over the implicit tree
    always_comb
    begin
        dmp_emit  = 1'b0;
        dmp_done  = 1'b0;
        dmp_slot  = slot_reg;
        dmp_phase = phase_reg;
        case (phase_reg)
            PH_DOWN:
            begin
                if (node_empty)
                begin
                    dmp_done  = up_done;
                    dmp_slot  = up_slot;
                    dmp_phase = up_phase;
                end
                else
                begin
                    dmp_emit  = (order_reg != ORD_IN) && (order_reg != ORD_POST);
                    dmp_slot  = left_slot;
                    dmp_phase = PH_DOWN;
                end
            end
            PH_LEFT:
            begin
                dmp_emit  = (order_reg == ORD_IN);
                dmp_slot  = right_slot;
                dmp_phase = PH_DOWN;
            end
            PH_RIGHT:
            begin
                dmp_emit  = (order_reg == ORD_POST);
                dmp_done  = up_done;
                dmp_slot  = up_slot;
                dmp_phase = up_phase;
            end
            default:
            begin
                dmp_done = 1'b1;
            end
        endcase
    end

    assign stall = dmp_emit && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        phase_next       = phase_reg;
        order_next       = order_reg;
        value_next       = value_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_resp_next    = clr_resp_reg;
        resp_status_next = resp_status_reg;
        pend_valid_next  = pend_valid_reg;
        pend_value_next  = pend_value_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    if (clr_resp_reg)
                    begin
                        resp_status_next = ST_OK;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_action)
                        ACT_INSERT:
                        begin
                            value_next = in_value;
                            slot_next  = ROOT;
                            if (in_value == '0)
                            begin
                                resp_status_next = ST_ZERO;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_DUMP:
                        begin
                            order_next      = in_order;
                            slot_next       = ROOT;
                            phase_next      = PH_DOWN;
                            pend_valid_next = 1'b0;
                            state_next      = S_DMP_RD;
                        end
                        ACT_CLEAR:
                        begin
                            clr_resp_next = 1'b1;
                            clr_cnt_next  = '0;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (slot_reg[LEVELS])
                begin
                    resp_status_next = ST_FULL;
                    state_next       = S_RESP;
                end
                else
                begin
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV:
            begin
                if (mem_rdata == '0)
                begin
                    resp_status_next = ST_OK;
                    state_next       = S_RESP;
                end
                else
                begin
                    slot_next  = go_left ? left_slot : right_slot;
                    state_next = S_INS_RD;
                end
            end
            S_DMP_RD:
            begin
                state_next = S_DMP_EV;
            end
            S_DMP_EV:
            begin
                if (!stall)
                begin
                    if (dmp_emit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_value_next = mem_rdata;
                    end
                    if (dmp_done)
                    begin
                        if (pend_valid_reg || dmp_emit)
                        begin
                            state_next = S_DMP_FLUSH;
                        end
                        else
                        begin
                            resp_status_next = ST_EMPTY;
                            state_next       = S_RESP;
                        end
                    end
                    else
                    begin
                        slot_next  = dmp_slot;
                        phase_next = dmp_phase;
                        state_next = S_DMP_RD;
                    end
                end
            end
            S_DMP_FLUSH:
            begin
                if (out_free)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        mem_re         = ((state_reg == S_INS_RD) || (state_reg == S_DMP_RD))
                         && !slot_reg[LEVELS];
        mem_raddr      = slot_m1[LEVELS-1:0];
        mem_we         = 1'b0;
        mem_waddr      = slot_m1[LEVELS-1:0];
        mem_wdata      = value_reg;
        res.load       = 1'b0;
        res.node_value = pend_value_reg;
        res.status     = ST_OK;
        res.last       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            S_INS_EV:
            begin
                mem_we = (mem_rdata == '0);
            end
            S_DMP_EV:
            begin
                res.load = dmp_emit && pend_valid_reg && out_free;
            end
            S_DMP_FLUSH:
            begin
                res.load = out_free;
                res.last = 1'b1;
            end
            S_RESP:
            begin
                res.load       = out_free;
                res.node_value = '0;
                res.status     = resp_status_reg;
                res.last       = 1'b1;
            end
            default:
            begin
                res.load = 1'b0;
            end
        endcase
    end

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("memory read and write in the same cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> out_free)
        else $error("result loaded into a busy output register");

    a_return_real: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DMP_EV && phase_reg != PH_DOWN) |-> !slot_reg[LEVELS])
        else $error("walk returned to a slot outside the tree");

    a_ins_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_EV |-> !slot_reg[LEVELS] && slot_reg != '0)
        else $error("insert compares at an invalid slot");

    a_pend_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP || state_reg == S_IDLE) |-> !pend_valid_reg
        || $past(state_reg) == S_DMP_FLUSH)
        else $error("pending dump value left behind");

endmodule
